// File: sv/fcr_pkg.sv
// Shared types and constants of the cubic Farrow resampler.
package fcr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int WIN_TAPS        = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int PHASE_W         = 17;
  localparam int JOB_QUEUE_DEPTH = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_NUM    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_DENOM  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t in_re;
    sample_t in_im;
  } in_beat_t;

  typedef struct packed {
    sample_t out_re;
    sample_t out_im;
    logic    run_last;
  } out_beat_t;

  // Element 0 is the oldest sample, element WIN_TAPS-1 the newest
  typedef struct packed {
    sample_t [WIN_TAPS-1:0] re;
    sample_t [WIN_TAPS-1:0] im;
  } win_t;

endpackage

// File: sv/fcr_queue.sv
// Short register queue between the phase sequencer and the Farrow datapath.
module fcr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue holds more entries than its depth");

endmodule

// File: sv/fcr_front.sv
// Front end: sample window, phase accumulator and bit-serial fraction divider.
module fcr_front #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fcr_pkg::in_beat_t                in_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fcr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             job_valid,
  input  logic                             job_ready,
  output fcr_pkg::win_t                    job_win,
  output logic [FRAC_BITS-1:0]             job_frac,
  output logic                             job_last
);

  import fcr_pkg::*;

  localparam int BIT_W  = $clog2(FRAC_BITS);
  localparam int RUN_W  = $clog2(MAX_OUTPUTS + 1);
  localparam int FILL_W = 3;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_TAPS);

  logic [1:0]            state;
  win_t                  win;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_next;
  logic [PHASE_W-1:0]    phase;
  logic [PHASE_W-1:0]    phase_step;
  logic [CFG_DATA_W-1:0] step_num;
  logic [CFG_DATA_W-1:0] step_denom;
  logic [CFG_DATA_W-1:0] den;
  logic [PHASE_W-1:0]    den_ext;
  logic [CFG_DATA_W-1:0] rem;
  logic [PHASE_W-1:0]    rem_dbl;
  logic                  rem_ge;
  logic [FRAC_BITS-1:0]  quot;
  logic [BIT_W-1:0]      bit_cnt;
  logic [RUN_W-1:0]      run_cnt;
  logic                  run_go;
  logic                  in_take;

  assign den        = (step_denom == '0) ? CFG_DATA_W'(1) : step_denom;
  assign den_ext    = {1'b0, den};
  assign phase_step = phase + {1'b0, step_num};
  assign fill_next  = (fill == FILL_FULL) ? fill : fill + 1'b1;
  assign run_go     = (run_cnt < RUN_W'(MAX_OUTPUTS)) && (phase < den_ext);
  assign rem_dbl    = {rem, 1'b0};
  assign rem_ge     = (rem_dbl >= den_ext);

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_take   = in_valid && in_ready;

  assign job_valid = (state == ST_PUSH);
  assign job_win   = win;
  assign job_frac  = quot;
  assign job_last  = (run_cnt == RUN_W'(MAX_OUTPUTS - 1)) || (phase_step >= den_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      phase      <= '0;
      step_num   <= CFG_DATA_W'(1);
      step_denom <= CFG_DATA_W'(1);
      run_cnt    <= '0;
      bit_cnt    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            fill    <= fill_next;
            run_cnt <= '0;
            if (fill_next == FILL_FULL) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (run_go) begin
            bit_cnt <= '0;
            state   <= ST_DIV;
          end else begin
            phase <= (phase >= den_ext) ? phase - den_ext : '0;
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BIT_W'(FRAC_BITS - 1)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (job_ready) begin
            phase   <= phase_step;
            run_cnt <= run_cnt + 1'b1;
            state   <= ST_CHECK;
          end
        end
      endcase

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEP_NUM:    step_num   <= cfg_data;
          REG_STEP_DENOM:  step_denom <= cfg_data;
          REG_START_PHASE: phase      <= {1'b0, cfg_data};
          default: ;
        endcase
      end
    end
  end

  // Window and divider datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      win.re <= {in_data.in_re, win.re[WIN_TAPS-1:1]};
      win.im <= {in_data.in_im, win.im[WIN_TAPS-1:1]};
    end
    if (state == ST_CHECK) begin
      rem  <= phase[CFG_DATA_W-1:0];
      quot <= '0;
    end else if (state == ST_DIV) begin
      rem  <= rem_ge ? CFG_DATA_W'(rem_dbl - den_ext) : rem_dbl[CFG_DATA_W-1:0];
      quot <= {quot[FRAC_BITS-2:0], rem_ge};
    end
  end

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    run_cnt <= RUN_W'(MAX_OUTPUTS))
    else $error("run count passed its cap");

  a_push_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> (phase < den_ext))
    else $error("job offered with phase not below the denominator");

  a_fill_sat: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count passed the window size");

endmodule

// File: sv/fcr_back.sv
// Back end: shared Horner multipliers, rounding, divide by six and saturation.
module fcr_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  fcr_pkg::win_t        job_win,
  input  logic [FRAC_BITS-1:0] job_frac,
  input  logic                 job_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fcr_pkg::out_beat_t   out_data
);

  import fcr_pkg::*;

  localparam int ACC_W      = SAMPLE_BITS + 7;
  localparam int PROD_W     = ACC_W + FRAC_BITS + 1;
  localparam int SAT_SPAN   = 6 * (2 ** (SAMPLE_BITS - 1));
  localparam int V_W        = SAMPLE_BITS + 2;
  localparam int DIV3_SHIFT = SAMPLE_BITS + 4;
  localparam int DIV3_MUL   = (2 ** DIV3_SHIFT + 2) / 3;
  localparam int MUL_W      = DIV3_SHIFT - 1;
  localparam int PQ_W       = V_W + MUL_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADD   = 3'd2;
  localparam logic [2:0] ST_CLAMP = 3'd3;
  localparam logic [2:0] ST_DIV3  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [1:0] LAST_STEP = 2'd2;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    acc_t k3;
    acc_t k2;
    acc_t k1;
    acc_t k0;
  } coef_t;

  localparam acc_t                ACC_THREE  = acc_t'(3);
  localparam acc_t                SAT_HI     = acc_t'(SAT_SPAN - 1);
  localparam acc_t                SAT_LO     = acc_t'(-SAT_SPAN);
  localparam acc_t                SAT_OFF    = acc_t'(SAT_SPAN);
  localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [MUL_W-1:0]    RECIP3     = MUL_W'(DIV3_MUL);

  // Coefficients scaled by six so that all of them are integers
  function automatic coef_t farrow_coefs(sample_t [WIN_TAPS-1:0] x);
    acc_t  x0;
    acc_t  x1;
    acc_t  x2;
    acc_t  x3;
    coef_t c;
    x0   = acc_t'($signed(x[0]));
    x1   = acc_t'($signed(x[1]));
    x2   = acc_t'($signed(x[2]));
    x3   = acc_t'($signed(x[3]));
    c.k3 = x3 - acc_t'(3) * x2 + acc_t'(3) * x1 - x0;
    c.k2 = acc_t'(6) * x2 - x3 - acc_t'(9) * x1 + acc_t'(4) * x0;
    c.k1 = x2 + acc_t'(4) * x1 - acc_t'(5) * x0;
    c.k0 = acc_t'(4) * x1 + acc_t'(2) * x0;
    return c;
  endfunction

  function automatic acc_t pick_coef(coef_t c, logic [1:0] s);
    acc_t k;
    unique case (s)
      2'd0:    k = c.k2;
      2'd1:    k = c.k1;
      default: k = c.k0;
    endcase
    return k;
  endfunction

  // Round to nearest, ties upward, then add the next coefficient
  function automatic acc_t round_add(prod_t p, acc_t k);
    logic signed [PROD_W:0] t;
    t = (PROD_W + 1)'(p) + ROUND_HALF;
    t = t >>> FRAC_BITS;
    return t[ACC_W-1:0] + k;
  endfunction

  // Add the rounding bias, clamp to the representable range, shift to
  // non-negative and halve; the divide by three follows
  function automatic logic [V_W-1:0] clamp_half(acc_t a);
    acc_t w;
    acc_t u;
    w = a + ACC_THREE;
    if (w > SAT_HI) begin
      w = SAT_HI;
    end else if (w < SAT_LO) begin
      w = SAT_LO;
    end
    u = w + SAT_OFF;
    return u[V_W:1];
  endfunction

  // Quotient lies in [0, 2^SAMPLE_BITS); flip the top bit to remove the offset
  function automatic sample_t unbias(logic [PQ_W-1:0] p);
    logic [SAMPLE_BITS-1:0] f;
    f = p[DIV3_SHIFT +: SAMPLE_BITS];
    return {~f[SAMPLE_BITS-1], f[SAMPLE_BITS-2:0]};
  endfunction

  logic [2:0]           state;
  logic [1:0]           step;
  coef_t                coef_re;
  coef_t                coef_im;
  acc_t                 acc_re;
  acc_t                 acc_im;
  prod_t                prod_re;
  prod_t                prod_im;
  logic [V_W-1:0]       v_re;
  logic [V_W-1:0]       v_im;
  logic [PQ_W-1:0]      pq_re;
  logic [PQ_W-1:0]      pq_im;
  logic signed [FRAC_BITS:0] frac;
  logic                 last;
  logic                 job_take;
  logic                 out_load;
  coef_t                new_re;
  coef_t                new_im;

  assign job_ready = (state == ST_IDLE);
  assign job_take  = job_valid && job_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);
  assign new_re    = farrow_coefs(job_win.re);
  assign new_im    = farrow_coefs(job_win.im);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_take) begin
            step  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL:   state <= ST_ADD;
        ST_ADD: begin
          step  <= step + 1'b1;
          state <= (step == LAST_STEP) ? ST_CLAMP : ST_MUL;
        end
        ST_CLAMP: state <= ST_DIV3;
        ST_DIV3:  state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      coef_re <= new_re;
      coef_im <= new_im;
      acc_re  <= new_re.k3;
      acc_im  <= new_im.k3;
      frac    <= {1'b0, job_frac};
      last    <= job_last;
    end
    if (state == ST_MUL) begin
      prod_re <= prod_t'(acc_re) * prod_t'(frac);
      prod_im <= prod_t'(acc_im) * prod_t'(frac);
    end
    if (state == ST_ADD) begin
      acc_re <= round_add(prod_re, pick_coef(coef_re, step));
      acc_im <= round_add(prod_im, pick_coef(coef_im, step));
    end
    if (state == ST_CLAMP) begin
      v_re <= clamp_half(acc_re);
      v_im <= clamp_half(acc_im);
    end
    if (state == ST_DIV3) begin
      pq_re <= PQ_W'(v_re) * PQ_W'(RECIP3);
      pq_im <= PQ_W'(v_im) * PQ_W'(RECIP3);
    end
    if (out_load) begin
      out_data <= '{out_re: unbias(pq_re), out_im: unbias(pq_im), run_last: last};
    end
  end

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("result not presented after load");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> (step <= LAST_STEP))
    else $error("Horner step beyond the constant term");

endmodule

// File: sv/cubic_farrow_resampler.sv
// Top level of the cubic Farrow fractional resampler for complex samples.
//
//  channel   signals                                direction  beat
//  -------   -------------------------------------  ---------  ------------------------
//  in        in_valid, in_ready, in_data            sink       one complex Q1.15 sample
//  out       out_valid, out_ready, out_data         source     one output plus run_last
//  cfg       cfg_valid, cfg_ready, cfg_index/_data  sink       one register write
//
// An input beat with R outputs keeps the input side busy until all R jobs are
// queued: the bit-serial divider that forms the fraction d = phase / step_denom
// for each output sets the rate, and a full job queue stalls it.
// The Farrow datapath works behind a two-entry job queue, so it overlaps the
// divider of the next output.
// Reset (rst, synchronous) clears the fill count, loads phase 0 and both steps 1.
// A stalled output holds in the output register while the next result is built;
// configuration beats are taken whenever the input side is idle.
module cubic_farrow_resampler #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  fcr_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fcr_pkg::out_beat_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fcr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import fcr_pkg::*;

  // Job word: window snapshot, fraction, last-of-run flag
  localparam int JOB_W = $bits(win_t) + FRAC_BITS + 1;

  win_t                 fr_win;
  logic [FRAC_BITS-1:0] fr_frac;
  logic                 fr_last;
  logic                 fr_valid;
  logic                 fr_ready;
  logic [JOB_W-1:0]     q_in;
  logic [JOB_W-1:0]     q_out;
  logic                 bk_valid;
  logic                 bk_ready;
  win_t                 bk_win;
  logic [FRAC_BITS-1:0] bk_frac;
  logic                 bk_last;

  // Front end: shift the window, advance the phase, form d for each output
  fcr_front #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job_win   (fr_win),
    .job_frac  (fr_frac),
    .job_last  (fr_last)
  );

  assign q_in = {fr_win, fr_frac, fr_last};

  // Decouple the divider from the polynomial datapath
  fcr_queue #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (q_in),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (q_out)
  );

  assign {bk_win, bk_frac, bk_last} = q_out;

  // Back end: evaluate the cubic, round, divide by six and saturate
  fcr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job_win   (bk_win),
    .job_frac  (bk_frac),
    .job_last  (bk_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/cubic_farrow_resampler_check.sv
// Checker of the cubic Farrow resampler: predicts output beats and compares them.
`timescale 1ns / 1ps

module cubic_farrow_resampler_check #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OUTPUTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  fcr_pkg::in_beat_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  fcr_pkg::out_beat_t              out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [fcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fcr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              error_count,
  output int                              outputs_pending
);

  import fcr_pkg::*;

  localparam longint SAT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));

  // Shadow of the resampler state
  sample_t               tap_re [WIN_TAPS];
  sample_t               tap_im [WIN_TAPS];
  logic [PHASE_W-1:0]    phase;
  int                    fill;
  logic [CFG_DATA_W-1:0] step_num;
  logic [CFG_DATA_W-1:0] step_denom;

  out_beat_t             pending_outputs [$];
  int                    errors = 0;

  // Shift right by FRAC_BITS, rounding to nearest with ties towards +inf
  function automatic longint round_frac(input longint v);
    return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // Cubic polynomial at fraction frac, all coefficients scaled by 6
  function automatic sample_t cubic_point(input sample_t x [WIN_TAPS], input longint frac);
    longint x0, x1, x2, x3, k3, k2, k1, k0, acc, w, q;
    x0  = x[0];
    x1  = x[1];
    x2  = x[2];
    x3  = x[3];
    k3  = x3 - 3 * x2 + 3 * x1 - x0;
    k2  = -x3 + 6 * x2 - 9 * x1 + 4 * x0;
    k1  = x2 + 4 * x1 - 5 * x0;
    k0  = 4 * x1 + 2 * x0;
    acc = round_frac(k3 * frac) + k2;
    acc = round_frac(acc * frac) + k1;
    acc = round_frac(acc * frac) + k0;
    w   = acc + 3;
    if (w >= 0) begin
      q = w / 6;
    end else begin
      q = -((-(w + 1)) / 6) - 1;
    end
    if (q > SAT_MAX) begin
      q = SAT_MAX;
    end else if (q < SAT_MIN) begin
      q = SAT_MIN;
    end
    return sample_t'(q);
  endfunction

  // Shift a sample in and queue the run of outputs that it starts
  function automatic void predict_run(input in_beat_t s);
    out_beat_t          beat;
    logic [PHASE_W-1:0] den;
    longint             frac;
    int                 n;
    for (int k = 0; k < WIN_TAPS - 1; k++) begin
      tap_re[k] = tap_re[k + 1];
      tap_im[k] = tap_im[k + 1];
    end
    tap_re[WIN_TAPS-1] = s.in_re;
    tap_im[WIN_TAPS-1] = s.in_im;
    if (fill < WIN_TAPS) begin
      fill++;
    end
    if (fill < WIN_TAPS) begin
      return;
    end
    den = (step_denom == '0) ? PHASE_W'(1) : PHASE_W'(step_denom);
    n   = 0;
    while (n < MAX_OUTPUTS && phase < den) begin
      frac          = (longint'(phase) <<< FRAC_BITS) / longint'(den);
      beat.out_re   = cubic_point(tap_re, frac);
      beat.out_im   = cubic_point(tap_im, frac);
      phase         = phase + PHASE_W'(step_num);
      n++;
      beat.run_last = !(n < MAX_OUTPUTS && phase < den);
      pending_outputs.push_back(beat);
    end
    if (phase >= den) begin
      phase = phase - den;
    end else begin
      phase = '0;
    end
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (rst) begin
      for (int k = 0; k < WIN_TAPS; k++) begin
        tap_re[k] = '0;
        tap_im[k] = '0;
      end
      phase      = '0;
      fill       = 0;
      step_num   = CFG_DATA_W'(1);
      step_denom = CFG_DATA_W'(1);
      pending_outputs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected output beat re %0d im %0d last %0b", $time,
                   out_data.out_re, out_data.out_im, out_data.run_last);
        end else begin
          want = pending_outputs.pop_front();
          if (out_data.out_re !== want.out_re) begin
            errors++;
            $display("%0t: out_re expected %0d, got %0d", $time, want.out_re, out_data.out_re);
          end
          if (out_data.out_im !== want.out_im) begin
            errors++;
            $display("%0t: out_im expected %0d, got %0d", $time, want.out_im, out_data.out_im);
          end
          if (out_data.run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b, got %0b", $time, want.run_last,
                     out_data.run_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_NUM:    step_num   = cfg_data;
          REG_STEP_DENOM:  step_denom = cfg_data;
          REG_START_PHASE: phase      = PHASE_W'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_run(in_data);
      end
    end
    error_count     <= errors;
    outputs_pending <= pending_outputs.size();
  end

endmodule

// File: tb/sv/cubic_farrow_resampler_test.sv
// Top of the cubic Farrow resampler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module cubic_farrow_resampler_test;
  import fcr_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_OUTPUTS = 16;

  // An item keeps the input side busy while the divider forms each of its R outputs
  localparam int QUIET_CYCLES   = 64;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 48;
  localparam int GAP_PCT        = 34;

  // No register lives at this index; a write to it must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_MIN = 16'sh8000;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_beat_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_beat_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int error_count;
  int outputs_pending;
  int cycle_count = 0;
  int gap_pct     = GAP_PCT;
  bit holdoff_req = 1'b0;

  cubic_farrow_resampler #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cubic_farrow_resampler_check #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) checker_inst (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .outputs_pending(outputs_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cubic_farrow_resampler: mismatch");
      $finish;
    end
  end

  // Output side: stall at random, or hold ready low for a long stretch when asked so
  // that the job queue and output register fill and the input side backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= gap_pct);
      end
    end
  end

  // Offer one sample beat and return at the edge that accepts it. Valid stays high
  // on return, so a following beat goes out back to back unless a random gap is drawn.
  task automatic send_sample(input sample_t re, input sample_t im);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_re: re, in_im: im};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // One register write beat; the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write the rate registers; leave the phase alone when keep_phase is set
  task automatic configure(input int num, input int den, input int phase0, input bit keep_phase);
    write_reg(REG_STEP_NUM, CFG_DATA_W'(num));
    write_reg(REG_STEP_DENOM, CFG_DATA_W'(den));
    if (!keep_phase) begin
      write_reg(REG_START_PHASE, CFG_DATA_W'(phase0));
    end
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted beat, then let an empty run finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outputs_pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Mostly full-range noise, with the rails thrown in now and then
  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0:       return S_MAX;
      1:       return S_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int num, den, phase0, hi, prev_num, prev_den;
    bit keep_phase;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset rates (one output per sample at d = 0); the first three beats only
    // fill the window and must produce nothing.
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(16'sd0, -16'sd1);
    send_sample(-16'sd1, 16'sd0);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);

    // Three outputs per sample at d = 0, 1/3, 2/3; alternate the rails so the
    // cubic overshoots and the output saturates.
    settle();
    configure(1, 3, 0, 1'b0);
    for (int k = 0; k < 8; k++) begin
      send_sample(k[0] ? S_MAX : S_MIN, k[0] ? S_MIN : S_MAX);
    end

    // Zero denominator behaves as one; a write to the spare index is dropped
    settle();
    write_reg(REG_STEP_NUM, CFG_DATA_W'(1));
    write_reg(REG_STEP_DENOM, '0);
    write_reg(REG_START_PHASE, '0);
    write_reg(REG_SPARE, '1);
    cfg_valid <= 1'b0;
    send_sample(random_sample(), random_sample());
    send_sample(random_sample(), random_sample());

    // Start phase above the denominator: the first two runs are empty
    settle();
    configure(5, 7, 20, 1'b0);
    repeat (3) send_sample(random_sample(), random_sample());

    // Tiny step against the largest modulus: every run hits the cap
    settle();
    configure(1, 65535, 0, 1'b0);
    repeat (2) send_sample(random_sample(), random_sample());

    prev_num = 1;
    prev_den = 65535;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          num    = 65535;
          den    = 65535;
          phase0 = 0;
        end
        1: begin
          // Largest step over a quarter of it: roughly one output in four samples
          num    = 65535;
          den    = 16384;
          phase0 = 16383;
        end
        default: begin
          den    = $urandom_range(65535, 2);
          hi     = (den * 4 > 65535) ? 65535 : den * 4;
          num    = (p == 4) ? den / 3 + 1 : $urandom_range(hi, den / 6 + 1);
          phase0 = $urandom_range(den - 1, 0);
        end
      endcase
      // Now and then change the ratio without reloading the phase; only where the
      // carried-over phase cannot starve the new modulus of outputs.
      keep_phase = (p > 2) && ($urandom_range(2) == 0) && (den >= prev_den) &&
                   (den >= prev_num);
      configure(num, den, phase0, keep_phase);
      prev_num = num;
      prev_den = den;

      gap_pct = (p == 3) ? 0 : GAP_PCT;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == 8) begin
          holdoff_req = 1'b1;
        end
        send_sample(random_sample(), random_sample());
      end
      gap_pct = GAP_PCT;
    end

    settle();
    if (error_count == 0) begin
      $display("cubic_farrow_resampler: match");
    end else begin
      $display("cubic_farrow_resampler: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/fcr_pkg.sv
sv/fcr_queue.sv
sv/fcr_front.sv
sv/fcr_back.sv
sv/cubic_farrow_resampler.sv
tb/sv/cubic_farrow_resampler_check.sv
tb/sv/cubic_farrow_resampler_test.sv
